// File: src/gvc_pkg.sv
`timescale 1ns / 1ps

package gvc_pkg;

    localparam int PRESS_W  = 27;
    localparam int Z_W      = 16;
    localparam int TEMP_W   = 16;
    localparam int VISC_W   = 24;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_INPUT = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    // Signed Q24 log2-domain word.
    typedef logic signed [47:0] lq_t;

    localparam lq_t LCR_Q     = 48'sd17050483;
    localparam lq_t LKN_Q     = 48'sd222035222;
    localparam lq_t LTR_OFF_Q = 48'sd86436269;
    localparam lq_t L20480_Q  = 48'sd240282107;
    localparam lq_t LX_OFF_Q  = 48'sd402653184;   // 24.0
    localparam lq_t LIM_E_Q   = 48'sd83886080;    // 5.0
    localparam lq_t LIM_L_Q   = 48'sd402653184;   // 24.0
    localparam lq_t E_FLOOR_Q = -48'sd1073741824; // -64.0

    localparam logic [39:0] XC_C      = 40'd60562961;
    localparam logic [39:0] YC_C      = 40'd41053848;
    localparam logic [21:0] CY_C      = 22'd3731253;
    localparam logic [24:0] LOG2E_C   = 25'd24204406;
    localparam logic [25:0] KD20480_C = 26'd10610927;
    localparam logic [39:0] DIV_NUM   = 40'd35072 << 24;
    localparam logic [VISC_W-1:0] VMAX_C = '1;

    typedef logic [23:0][30:0] root_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bit_v;
        res = '0;
        rem = x;
        for (int i = 0; i < 32; i++) begin
            bit_v = 64'd1 << (62 - 2 * i);
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
        end
        return res;
    endfunction

    // Q30 factors 2^(2^-k), k = 1..24, each a floor square root of the last.
    function automatic root_tab_t make_roots();
        root_tab_t tab;
        logic [63:0] r;
        r = isqrt64(64'd1 << 61);
        for (int k = 0; k < 24; k++) begin
            tab[k] = r[30:0];
            r = isqrt64(r << 30);
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT = make_roots();

endpackage

// File: src/gvc_in_if.sv
`timescale 1ns / 1ps

interface gvc_in_if;
    import gvc_pkg::*;

    logic                valid;
    logic                ready;
    logic [PRESS_W-1:0]  pressure_pa;
    logic [Z_W-1:0]      z_factor;
    logic [TEMP_W-1:0]   temperature;

    modport source (output valid, output pressure_pa, output z_factor, output temperature,
                    input ready);
    modport sink   (input valid, input pressure_pa, input z_factor, input temperature,
                    output ready);
endinterface

// File: src/gvc_out_if.sv
`timescale 1ns / 1ps

interface gvc_out_if;
    import gvc_pkg::*;

    logic                valid;
    logic                ready;
    logic [VISC_W-1:0]   viscosity;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output viscosity, output status, input ready);
    modport sink   (input valid, input viscosity, input status, output ready);
endinterface

// File: src/gas_viscosity_correlation.sv
`timescale 1ns / 1ps
// Gas viscosity pipeline: 106 register stages plus an output register.
// Throughput is one beat per cycle unless the full output register is not being
// drained; the squaring chain costs one 31x31 multiply per operand per stage,
// the root-product chains one per stage, and together they set the depth.
// Reset (rst_n low, asynchronous) clears the stage valid bits and the output valid.

module gas_viscosity_correlation (
    input  logic       clk,
    input  logic       rst_n,
    gvc_in_if.sink     feed,
    gvc_out_if.source  result
);
    import gvc_pkg::*;

    // Stage map. Each stage does one step of the correlation.
    localparam int ST_CAP  = 0;             // flags, 576*t + offset
    localparam int ST_DIV  = 1;             // 20 stages, two quotient bits each
    localparam int DIV_N   = 20;
    localparam int ST_XQ   = ST_DIV + DIV_N;
    localparam int ST_NORM = ST_XQ + 1;     // log2 normalize, X*CY product
    localparam int ST_SQ   = ST_NORM + 1;   // 24 squaring steps
    localparam int SQ_N    = 24;
    localparam int ST_C1   = ST_SQ + SQ_N;
    localparam int ST_C2   = ST_C1 + 1;
    localparam int ST_C3   = ST_C2 + 1;
    localparam int ST_C4   = ST_C3 + 1;
    localparam int ST_E1P  = ST_C4 + 1;     // first 2^x: exponent
    localparam int ST_E1M  = ST_E1P + 1;
    localparam int EXP_N   = 24;
    localparam int ST_E1S  = ST_E1M + EXP_N;
    localparam int ST_E1L  = ST_E1S + 1;
    localparam int ST_L    = ST_E1L + 1;
    localparam int ST_E2P  = ST_L + 1;      // second 2^x: viscosity
    localparam int ST_E2M  = ST_E2P + 1;
    localparam int ST_E2S  = ST_E2M + EXP_N;
    localparam int ST_OUT  = ST_E2S + 1;
    localparam int NSTAGE  = ST_OUT + 1;

    localparam int LG_COUNT = 5;
    localparam logic [2:0] LG_P = 3'd0;
    localparam logic [2:0] LG_Z = 3'd1;
    localparam logic [2:0] LG_T = 3'd2;
    localparam logic [2:0] LG_U = 3'd3;
    localparam logic [2:0] LG_X = 3'd4;

    typedef struct packed {
        logic                bad;
        logic                pzero;
        logic                sat;
        logic                zero_e;
        logic                yneg;
        logic                rneg;
        logic                e_zero;
        logic [PRESS_W-1:0]  p;
        logic [Z_W-1:0]      z;
        logic [TEMP_W-1:0]   t;
        logic [25:0]         u;
        logic [15:0]         rem;
        logic [39:0]         q;
        logic [39:0]         xq;
        logic [61:0]         yprod;
        logic [39:0]         yq;
        logic [LG_COUNT-1:0][5:0]  lg_n;
        logic [LG_COUNT-1:0][30:0] lg_m;
        logic [LG_COUNT-1:0][23:0] lg_fr;
        lq_t                 lx;
        lq_t                 lrho;
        lq_t                 lt;
        lq_t                 dn;
        lq_t                 lk;
        lq_t                 le;
        lq_t                 l;
        logic [37:0]         a;
        logic [29:0]         b;
        logic [43:0]         hi;
        logic [53:0]         lo;
        logic [44:0]         mag;
        logic [7:0]          e_n;
        logic [23:0]         e_f;
        logic [30:0]         e_m;
        logic [37:0]         e_val;
        logic [62:0]         e_prod;
        logic [24:0]         v;
        logic [VISC_W-1:0]   visc;
        status_t             status;
    } stage_t;

    typedef struct packed {
        logic [5:0]  n;
        logic [30:0] m;
    } norm_t;

    // One restoring-division bit.
    function automatic logic [16:0] div_bit(input logic [15:0] rem, input logic [15:0] t,
                                            input logic dbit);
        logic [16:0] r2;
        logic        qb;
        r2 = {rem, dbit};
        qb = 1'b0;
        if (r2 >= {1'b0, t}) begin
            r2 = r2 - {1'b0, t};
            qb = 1'b1;
        end
        return {qb, r2[15:0]};
    endfunction

    // Leading-one position and Q30 mantissa.
    function automatic norm_t lg_norm(input logic [39:0] x);
        norm_t r;
        r.n = '0;
        for (int i = 0; i < 40; i++) begin
            if (x[i]) begin
                r.n = 6'(i);
            end
        end
        if (r.n > 6'd30) begin
            r.m = 31'(x >> (r.n - 6'd30));
        end else begin
            r.m = 31'(x << (6'd30 - r.n));
        end
        return r;
    endfunction

    function automatic lq_t lg_val(input stage_t c, input logic [2:0] g);
        return $signed({18'd0, c.lg_n[g], c.lg_fr[g]});
    endfunction

    function automatic stage_t exp_prep(input stage_t c, input lq_t x);
        stage_t r;
        r = c;
        r.e_zero = (x <= E_FLOOR_Q);
        r.e_n    = 8'(x >>> 24);
        r.e_f    = x[23:0];
        r.e_m    = 31'h4000_0000;
        return r;
    endfunction

    function automatic stage_t exp_mul(input stage_t c, input logic [4:0] k0);
        stage_t      r;
        logic [61:0] pr;
        r  = c;
        pr = 62'(c.e_m) * 62'(ROOT[k0]);
        if (c.e_f[5'd23 - k0]) begin
            r.e_m = pr[60:30];
        end
        return r;
    endfunction

    function automatic stage_t stage_step(input int idx, input stage_t c);
        stage_t          r;
        norm_t           nm;
        logic [16:0]     d0;
        logic [16:0]     d1;
        logic [5:0]      j0;
        logic [61:0]     sq;
        logic [31:0]     m2;
        lq_t             t3;
        lq_t             half;
        lq_t             lpow;
        logic signed [8:0] s9;
        logic [5:0]      sh;
        logic [30:0]     rr;
        r = c;
        if (idx == ST_CAP) begin
            r.bad   = (c.z == '0) || (c.t == '0);
            r.pzero = (c.p == '0);
            r.u     = 26'(c.t) * 26'd576 + KD20480_C;
            r.rem   = '0;
            r.q     = '0;
        end else if (idx >= ST_DIV && idx < ST_XQ) begin
            j0    = 6'(39 - 2 * (idx - ST_DIV));
            d0    = div_bit(c.rem, c.t, DIV_NUM[j0]);
            d1    = div_bit(d0[15:0], c.t, DIV_NUM[j0 - 6'd1]);
            r.rem = d1[15:0];
            r.q   = {c.q[37:0], d0[16], d1[16]};
        end else if (idx == ST_XQ) begin
            r.xq = c.q + XC_C;
        end else if (idx == ST_NORM) begin
            for (int g = 0; g < LG_COUNT; g++) begin
                case (g)
                    0:       nm = lg_norm(40'(c.p));
                    1:       nm = lg_norm(40'(c.z));
                    2:       nm = lg_norm(40'(c.t));
                    3:       nm = lg_norm(40'(c.u));
                    default: nm = lg_norm(c.xq);
                endcase
                r.lg_n[g]  = nm.n;
                r.lg_m[g]  = nm.m;
                r.lg_fr[g] = '0;
            end
            r.yprod = 62'(c.xq) * 62'(CY_C);
        end else if (idx >= ST_SQ && idx < ST_C1) begin
            for (int g = 0; g < LG_COUNT; g++) begin
                sq         = 62'(c.lg_m[g]) * 62'(c.lg_m[g]);
                m2         = sq[61:30];
                r.lg_fr[g] = {c.lg_fr[g][22:0], m2[31]};
                r.lg_m[g]  = m2[31] ? m2[31:1] : m2[30:0];
            end
            if (idx == ST_SQ) begin
                r.yq = YC_C - {2'b00, c.yprod[61:24]};
            end
        end else if (idx == ST_C1) begin
            r.lx   = lg_val(c, LG_X) - LX_OFF_Q;
            r.lrho = LCR_Q + lg_val(c, LG_P) - lg_val(c, LG_Z) - lg_val(c, LG_T);
            r.lt   = lg_val(c, LG_T) - LTR_OFF_Q;
            r.dn   = lg_val(c, LG_U) - L20480_Q;
            r.yneg = c.yq[39];
            r.a    = 38'(c.yq[39] ? -$signed(c.yq) : $signed(c.yq));
        end else if (idx == ST_C2) begin
            r.rneg = (c.lrho < 0);
            r.b    = 30'((c.lrho < 0) ? -c.lrho : c.lrho);
            r.hi   = 44'(c.a[37:24]) * 44'(r.b);
            r.lo   = 54'(c.a[23:0]) * 54'(r.b);
            t3     = c.lt + (c.lt <<< 1);
            half   = (t3 < 0 && t3[0]) ? ((t3 + lq_t'(1)) >>> 1) : (t3 >>> 1);
            r.lk   = LKN_Q + half - c.dn;
        end else if (idx == ST_C3) begin
            r.mag = 45'(c.hi) + 45'(c.lo[53:24]);
        end else if (idx == ST_C4) begin
            lpow     = (c.yneg != c.rneg) ? -lq_t'(c.mag) : lq_t'(c.mag);
            r.sat    = 1'b0;
            r.zero_e = 1'b0;
            if (c.pzero) begin
                r.le = c.lx;
                if (!c.yneg && c.yq != '0) begin
                    r.zero_e = 1'b1;
                end else if (c.yneg) begin
                    r.sat = 1'b1;
                end
            end else begin
                r.le = c.lx + lpow;
            end
            if (!r.sat && !r.zero_e && r.le >= LIM_E_Q) begin
                r.sat = 1'b1;
            end
        end else if (idx == ST_E1P) begin
            r = exp_prep(c, c.le);
        end else if (idx >= ST_E1M && idx < ST_E1S) begin
            r = exp_mul(c, 5'(idx - ST_E1M));
        end else if (idx == ST_E1S) begin
            s9 = $signed({c.e_n[7], c.e_n}) + 9'sd2;
            sh = 6'(-s9);
            if (c.e_zero || c.zero_e) begin
                r.e_val = '0;
            end else if (s9 >= 0) begin
                r.e_val = 38'(c.e_m) << s9[3:0];
            end else begin
                r.e_val = 38'(c.e_m >> sh);
            end
        end else if (idx == ST_E1L) begin
            r.e_prod = 63'(c.e_val) * 63'(LOG2E_C);
        end else if (idx == ST_L) begin
            r.l = c.lk + lq_t'(c.e_prod[62:32]);
            if (r.l >= LIM_L_Q) begin
                r.sat = 1'b1;
            end
        end else if (idx == ST_E2P) begin
            r = exp_prep(c, c.l);
        end else if (idx >= ST_E2M && idx < ST_E2S) begin
            r = exp_mul(c, 5'(idx - ST_E2M));
        end else if (idx == ST_E2S) begin
            s9 = 9'sd29 - $signed({c.e_n[7], c.e_n});
            rr = c.e_m >> s9[6:0];
            if (c.e_zero) begin
                rr = '0;
            end
            r.v = 25'((26'(rr[24:0]) + 26'd1) >> 1);
        end else begin
            if (c.bad) begin
                r.visc   = '0;
                r.status = STATUS_BAD_INPUT;
            end else if (c.sat || c.v[24]) begin
                r.visc   = VMAX_C;
                r.status = STATUS_SATURATED;
            end else begin
                r.visc   = c.v[23:0];
                r.status = STATUS_OK;
            end
        end
        return r;
    endfunction

    stage_t              in_stage;
    stage_t              pipe_reg  [NSTAGE];
    stage_t              pipe_next [NSTAGE];
    logic [NSTAGE-1:0]   valid_reg;
    logic                advance;
    logic                out_valid_reg;
    logic [VISC_W-1:0]   out_visc_reg;
    status_t             out_status_reg;

    // Hold the whole pipe only when the last stage has a beat and the output
    // register is full and not being drained; bubbles elsewhere are held too.
    assign advance    = !valid_reg[NSTAGE-1] || !out_valid_reg || result.ready;
    assign feed.ready = advance;

    // Load the raw fields; every other field starts at zero.
    always_comb
    begin
        in_stage   = '0;
        in_stage.p = feed.pressure_pa;
        in_stage.z = feed.z_factor;
        in_stage.t = feed.temperature;
    end

    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        if (i == 0) begin : g_first
            always_comb
            begin
                pipe_next[i] = stage_step(i, in_stage);
            end
        end else begin : g_rest
            always_comb
            begin
                pipe_next[i] = stage_step(i, pipe_reg[i-1]);
            end
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NSTAGE-2:0], feed.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pipe_reg <= pipe_next;
        end
    end

    // Output register: take the last stage whenever the register is free
    // or being drained this cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            out_valid_reg <= valid_reg[NSTAGE-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_visc_reg   <= pipe_reg[NSTAGE-1].visc;
            out_status_reg <= pipe_reg[NSTAGE-1].status;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.viscosity = out_visc_reg;
    assign result.status    = out_status_reg;

endmodule
